@@ hw/rtl/ouvl_pkg.sv @@
package ouvl_pkg;

   localparam int OP_W     = 2;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 4;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 5;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_READ   = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_DUP      = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_RANGE    = 3'd5;

endpackage

@@ hw/rtl/ordered_unique_value_list_unit.sv @@
// An insert on a non-empty list that is not full, and a remove on a non-empty list, scan the list:
// each stored entry is read back from the list memory and compared before the result is loaded.
// A read, an insert on an empty or full list, a remove or read on an empty list and an unknown
// operation go straight to the result without a scan.
// One operation is in progress at a time; the next beat is taken the cycle after the result is
// loaded, while that result may still wait on the output.
// Synchronous reset empties the list and clears the output; no memory clearing pass is needed.
module ordered_unique_value_list_unit #(
   parameter int CAPACITY = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // item_value [31:0], position [35:32], zero padding above.
   input  logic [ouvl_pkg::REQ_DATA_W-1:0]   req_tdata,
   // operation [1:0].
   input  logic [ouvl_pkg::OP_W-1:0]         req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // entry_count [4:0], read_value [36:5], is_empty [37], is_full [38], zero padding above.
   output logic [ouvl_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // status [2:0].
   output logic [ouvl_pkg::STATUS_W-1:0]     rsp_tuser
);

   import ouvl_pkg::*;

   localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = CNT_W + POS_W;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type            state_ff, state_in;
   logic [OP_W-1:0]      op_ff, op_in;
   logic [VALUE_W-1:0]   val_ff, val_in;
   logic                 early_ff, early_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic                 hit_ff, hit_in;
   logic [CNT_W-1:0]     rd_addr_ff, rd_addr_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic [VALUE_W-1:0]   rsp_value_ff, rsp_value_in;
   logic                 rsp_empty_ff, rsp_empty_in;
   logic                 rsp_full_ff, rsp_full_in;

   logic                 ram_wr_en;
   logic [AW-1:0]        ram_wr_addr;
   logic [VALUE_W-1:0]   ram_wr_data;
   logic                 ram_rd_en;
   logic [AW-1:0]        ram_rd_addr;
   logic [VALUE_W-1:0]   ram_rd_data;

   logic                 accept;
   logic                 out_free;
   logic [OP_W-1:0]      req_op;
   logic [VALUE_W-1:0]   req_val;
   logic [CMP_W-1:0]     pos_wide;
   logic [CMP_W-1:0]     count_wide;
   logic [CNT_W-1:0]     back_addr;
   logic                 match;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_op     = req_tuser;
   assign req_val    = req_tdata[VALUE_W-1:0];
   assign pos_wide   = CMP_W'(req_tdata[VALUE_W+POS_W-1:VALUE_W]);
   assign count_wide = CMP_W'(count_ff);
   assign back_addr  = rd_addr_ff - CNT_W'(2);
   assign match      = (ram_rd_data == val_ff);

   ouvl_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      val_in        = val_ff;
      early_in      = early_ff;
      status_in     = status_ff;
      hit_in        = hit_ff;
      rd_addr_in    = rd_addr_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_full_in   = rsp_full_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = '0;
      ram_wr_data   = val_ff;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in      = req_op;
               val_in     = req_val;
               hit_in     = 1'b0;
               early_in   = 1'b1;
               status_in  = STATUS_OK;
               rd_addr_in = CNT_W'(1);
               state_in   = ST_FINISH;
               case (req_op)
                  OP_INSERT: begin
                     if (count_ff >= CNT_W'(CAPACITY)) begin
                        status_in = STATUS_FULL;
                     end else if (count_ff == '0) begin
                        early_in = 1'b0;
                     end else begin
                        early_in  = 1'b0;
                        ram_rd_en = 1'b1;
                        state_in  = ST_SCAN;
                     end
                  end
                  OP_REMOVE: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_EMPTY;
                     end else begin
                        early_in  = 1'b0;
                        ram_rd_en = 1'b1;
                        state_in  = ST_SCAN;
                     end
                  end
                  OP_READ: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_EMPTY;
                     end else if (pos_wide >= count_wide) begin
                        status_in = STATUS_RANGE;
                     end else begin
                        early_in    = 1'b0;
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = pos_wide[AW-1:0];
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // Once the match is found on a remove, each later entry moves one place toward the head.
            if (op_ff == OP_REMOVE && hit_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = back_addr[AW-1:0];
               ram_wr_data = ram_rd_data;
            end else if (match) begin
               hit_in = 1'b1;
            end
            if (rd_addr_ff < count_ff) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = rd_addr_ff[AW-1:0];
               rd_addr_in  = rd_addr_ff + CNT_W'(1);
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_value_in  = '0;
               state_in      = ST_IDLE;
               if (early_ff) begin
                  rsp_status_in = status_ff;
               end else begin
                  case (op_ff)
                     OP_INSERT: begin
                        if (hit_ff) begin
                           rsp_status_in = STATUS_DUP;
                        end else begin
                           ram_wr_en   = 1'b1;
                           ram_wr_addr = count_ff[AW-1:0];
                           count_in    = count_ff + CNT_W'(1);
                        end
                     end
                     OP_REMOVE: begin
                        if (hit_ff) begin
                           count_in = count_ff - CNT_W'(1);
                        end else begin
                           rsp_status_in = STATUS_NOTFOUND;
                        end
                     end
                     OP_READ: begin
                        rsp_value_in = ram_rd_data;
                     end
                     default: begin
                     end
                  endcase
               end
               rsp_count_in = COUNT_W'(count_in);
               rsp_empty_in = (count_in == '0);
               rsp_full_in  = (count_in == CNT_W'(CAPACITY));
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      val_ff        <= val_in;
      early_ff      <= early_in;
      status_ff     <= status_in;
      hit_ff        <= hit_in;
      rd_addr_ff    <= rd_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_full_ff   <= rsp_full_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_full_ff, rsp_empty_ff, rsp_value_ff, rsp_count_ff});

endmodule

@@ hw/rtl/ouvl_ram.sv @@
module ouvl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/ouvl_checker.sv @@
module ouvl_checker #(
   parameter int CAPACITY = 16
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [ouvl_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [ouvl_pkg::STATUS_W-1:0]   rsp_tuser
);

   import ouvl_pkg::*;

   logic req_beat;

   assign req_beat = req_tvalid && req_tready;

   // A result beat never shows up in the cycle right after reset.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result beat changed");

   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != STATUS_OK) |-> (rsp_tdata[36:5] == '0))
      else $error("refused operation returned a nonzero value");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[37] |-> (rsp_tdata[4:0] == '0) && !rsp_tdata[38])
      else $error("empty flag disagrees with count or full flag");

   // A result beat never directly follows an operation accepted while no result beat was valid.
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      req_beat && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result beat appeared one cycle after request");

endmodule

bind ordered_unique_value_list_unit ouvl_checker #(.CAPACITY(CAPACITY)) u_ouvl_checker (.*);

@@ dv/ordered_unique_value_list_unit_tb.sv @@
`timescale 1ns / 1ps

module ordered_unique_value_list_unit_tb;
   import ouvl_pkg::*;

   localparam int LIST_CAP = 16;
   localparam int RANDOM_ITEMS = 640;
   localparam int QUIET_TAIL = 80;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  entry_count;
      logic [VALUE_W-1:0]  read_value;
      logic                is_empty;
      logic                is_full;
   } list_result_type;

   class list_scoreboard;
      logic [VALUE_W-1:0] entries[LIST_CAP];
      int unsigned        count;
      list_result_type    expected_q[$];
      int                 errors;

      function new();
         count = 0;
         errors = 0;
      endfunction

      function int unsigned find(logic [VALUE_W-1:0] value);
         for (int unsigned i = 0; i < count; i++) begin
            if (entries[i] == value) return i;
         end
         return LIST_CAP;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value,
                                 logic [POS_W-1:0] pos);
         list_result_type res;
         int unsigned     idx;
         res.status = STATUS_OK;
         res.read_value = '0;
         case (op)
            OP_INSERT: begin
               if (count >= LIST_CAP) res.status = STATUS_FULL;
               else if (find(value) < LIST_CAP) res.status = STATUS_DUP;
               else begin
                  entries[count] = value;
                  count++;
               end
            end
            OP_REMOVE: begin
               if (count == 0) res.status = STATUS_EMPTY;
               else begin
                  idx = find(value);
                  if (idx >= LIST_CAP) res.status = STATUS_NOTFOUND;
                  else begin
                     for (int unsigned i = idx; i + 1 < count; i++) entries[i] = entries[i + 1];
                     count--;
                  end
               end
            end
            OP_READ: begin
               if (count == 0) res.status = STATUS_EMPTY;
               else if (int'(pos) >= count) res.status = STATUS_RANGE;
               else res.read_value = entries[pos];
            end
            default: begin
            end
         endcase
         res.entry_count = count[COUNT_W-1:0];
         res.is_empty = (count == 0);
         res.is_full = (count == LIST_CAP);
         expected_q.push_back(res);
      endfunction

      function void compare_field(string name, logic [VALUE_W-1:0] exp_v,
                                  logic [VALUE_W-1:0] act_v);
         if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            errors++;
         end
      endfunction

      function void check_response(logic [STATUS_W-1:0] status, logic [RSP_DATA_W-1:0] data);
         list_result_type exp_r;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, actual status %h data %h",
                     $time, status, data);
            errors++;
            return;
         end
         exp_r = expected_q.pop_front();
         compare_field("status", 32'(exp_r.status), 32'(status));
         compare_field("entry_count", 32'(exp_r.entry_count), 32'(data[4:0]));
         compare_field("read_value", exp_r.read_value, data[36:5]);
         compare_field("is_empty", 32'(exp_r.is_empty), 32'(data[37]));
         compare_field("is_full", 32'(exp_r.is_full), 32'(data[38]));
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic [OP_W-1:0]         req_tuser = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic [STATUS_W-1:0]     rsp_tuser;

   list_scoreboard sb;
   bit             stalls_on = 1'b1;
   int             stall_left = 0;

   ordered_unique_value_list_unit #(
      .CAPACITY(LIST_CAP)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (stalls_on && $urandom_range(0, 3) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 3);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tuser, rsp_tdata);
   end

   task automatic send_beat(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value,
                            input logic [POS_W-1:0] pos);
      @(negedge clock);
      if (stalls_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {4'b0, pos, value};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(op, value, pos);
   endtask

   task automatic wait_drained();
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic send_random(input int mode);
      int                 r;
      int                 ins_pct;
      int                 rem_pct;
      logic [OP_W-1:0]    op;
      logic [VALUE_W-1:0] value;
      logic [POS_W-1:0]   pos;
      ins_pct = (mode == 0) ? 70 : (mode == 1) ? 15 : 35;
      rem_pct = (mode == 0) ? 10 : (mode == 1) ? 60 : 30;
      r = $urandom_range(0, 99);
      if (r < ins_pct) op = OP_INSERT;
      else if (r < ins_pct + rem_pct) op = OP_REMOVE;
      else if (r < 95) op = OP_READ;
      else op = OP_UNUSED;
      value = $urandom();
      pos = POS_W'($urandom_range(0, 15));
      r = $urandom_range(0, 99);
      if (op == OP_INSERT || op == OP_REMOVE) begin
         if (sb.count > 0 && ((op == OP_INSERT && r < 15) || (op == OP_REMOVE && r < 65)))
            value = sb.entries[$urandom_range(0, sb.count - 1)];
         else if (r < 85 && r >= 65)
            value = $urandom_range(0, 15) - 8;
      end else if (op == OP_READ && sb.count > 0 && r < 60) begin
         pos = POS_W'($urandom_range(0, sb.count - 1));
      end
      send_beat(op, value, pos);
   endtask

   initial begin
      int mode;
      int phase_len;
      int items_sent;
      bit pause_done;
      sb = new();
      items_sent = 0;
      pause_done = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_beat(OP_READ, 32'h0000_0000, 4'd0);
      send_beat(OP_REMOVE, 32'h0000_0005, 4'd0);
      send_beat(OP_UNUSED, 32'hFFFF_FFFF, 4'd15);
      send_beat(OP_INSERT, 32'h8000_0000, 4'd0);
      send_beat(OP_INSERT, 32'h7FFF_FFFF, 4'd15);
      send_beat(OP_INSERT, 32'h0000_0000, 4'd0);
      send_beat(OP_INSERT, 32'hFFFF_FFFF, 4'd0);
      send_beat(OP_INSERT, 32'h7FFF_FFFF, 4'd0);
      send_beat(OP_READ, 32'h0000_0000, 4'd0);
      send_beat(OP_READ, 32'h0000_0000, 4'd3);
      send_beat(OP_READ, 32'h0000_0000, 4'd4);
      send_beat(OP_READ, 32'hFFFF_FFFF, 4'd15);
      send_beat(OP_REMOVE, 32'h1234_5678, 4'd0);
      send_beat(OP_REMOVE, 32'h7FFF_FFFF, 4'd0);
      send_beat(OP_READ, 32'h0000_0000, 4'd1);
      send_beat(OP_UNUSED, 32'h5A5A_5A5A, 4'd7);
      send_beat(OP_REMOVE, 32'h8000_0000, 4'd0);
      send_beat(OP_REMOVE, 32'hFFFF_FFFF, 4'd0);
      send_beat(OP_READ, 32'h0000_0000, 4'd0);

      while (items_sent < RANDOM_ITEMS) begin
         mode = $urandom_range(0, 2);
         phase_len = $urandom_range(20, 60);
         stalls_on = ($urandom_range(0, 3) != 0);
         if (!pause_done && items_sent >= RANDOM_ITEMS / 2) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            wait_drained();
            pause_done = 1'b1;
         end
         for (int k = 0; k < phase_len && items_sent < RANDOM_ITEMS; k++) begin
            if (items_sent >= RANDOM_ITEMS - QUIET_TAIL) stalls_on = 1'b0;
            send_random(mode);
            items_sent++;
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      wait_drained();
      repeat (40) @(posedge clock);
      if (sb.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
